/* sv/mseu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mseu_pkg
// Shared types and constants for the integer execute unit: instruction
// classes, operation codes, status codes, queue entry and back-end states.
// ----------------------------------------------------------------------------
package mseu_pkg;

  localparam int unsigned DATA_BYTES_DEF = 65536;
  localparam int unsigned QDEPTH         = 2;
  localparam logic [31:0] DATA_BASE      = 32'h2000_0000;

  // Instruction class carried in func
  localparam logic [1:0] FN_RTYPE   = 2'd0;
  localparam logic [1:0] FN_ITYPE   = 2'd1;
  localparam logic [1:0] FN_JTYPE   = 2'd2;
  localparam logic [1:0] FN_PRELOAD = 2'd3;

  // R-type funct codes
  localparam logic [5:0] RF_MFHI = 6'd16;
  localparam logic [5:0] RF_MFLO = 6'd18;
  localparam logic [5:0] RF_DIV  = 6'd26;
  localparam logic [5:0] RF_DIVU = 6'd27;
  localparam logic [5:0] RF_ADDU = 6'd33;
  localparam logic [5:0] RF_AND  = 6'd36;

  // I-type opcodes
  localparam logic [5:0] IO_ADDIU = 6'd9;
  localparam logic [5:0] IO_ANDI  = 6'd12;
  localparam logic [5:0] IO_LB    = 6'd32;
  localparam logic [5:0] IO_LH    = 6'd33;
  localparam logic [5:0] IO_LBU   = 6'd36;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_BADMEM  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_PRELOAD,
    OP_MFHI,
    OP_MFLO,
    OP_DIV,
    OP_DIVU,
    OP_ADDU,
    OP_AND,
    OP_ADDIU,
    OP_ANDI,
    OP_LB,
    OP_LH,
    OP_LBU,
    OP_INVALID
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [4:0]         src1;
    logic [4:0]         src2;
    logic [4:0]         dest;
    logic signed [15:0] immediate;
    logic [15:0]        preload_offset;
    logic [7:0]         preload_byte;
  } entry_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_READ,
    BS_DIV,
    BS_MEM0,
    BS_MEM1,
    BS_DONE
  } bstate_t;

endpackage

/* sv/mseu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mseu_front
// Input side: takes transfers and classifies func/code into one operation.
// ----------------------------------------------------------------------------
module mseu_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [5:0]         code,
  input  logic [4:0]         src1,
  input  logic [4:0]         src2,
  input  logic [4:0]         dest,
  input  logic signed [15:0] immediate,
  input  logic [15:0]        preload_offset,
  input  logic [7:0]         preload_byte,
  input  logic               q_full,
  input  logic               clearing,
  output logic               push,
  output mseu_pkg::entry_t   push_entry
);

  mseu_pkg::op_t op;

  // Decode the instruction class and code
  always_comb begin
    op = mseu_pkg::OP_INVALID;
    unique case (func)
      mseu_pkg::FN_PRELOAD: op = mseu_pkg::OP_PRELOAD;
      mseu_pkg::FN_RTYPE: begin
        unique case (code)
          mseu_pkg::RF_MFHI: op = mseu_pkg::OP_MFHI;
          mseu_pkg::RF_MFLO: op = mseu_pkg::OP_MFLO;
          mseu_pkg::RF_DIV:  op = mseu_pkg::OP_DIV;
          mseu_pkg::RF_DIVU: op = mseu_pkg::OP_DIVU;
          mseu_pkg::RF_ADDU: op = mseu_pkg::OP_ADDU;
          mseu_pkg::RF_AND:  op = mseu_pkg::OP_AND;
          default:           op = mseu_pkg::OP_INVALID;
        endcase
      end
      mseu_pkg::FN_ITYPE: begin
        unique case (code)
          mseu_pkg::IO_ADDIU: op = mseu_pkg::OP_ADDIU;
          mseu_pkg::IO_ANDI:  op = mseu_pkg::OP_ANDI;
          mseu_pkg::IO_LB:    op = mseu_pkg::OP_LB;
          mseu_pkg::IO_LH:    op = mseu_pkg::OP_LH;
          mseu_pkg::IO_LBU:   op = mseu_pkg::OP_LBU;
          default:            op = mseu_pkg::OP_INVALID;
        endcase
      end
      default: op = mseu_pkg::OP_INVALID;
    endcase
  end

  // Hold off transfers while the queue is full or the store is being cleared
  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  assign push_entry = '{op:             op,
                        src1:           src1,
                        src2:           src2,
                        dest:           dest,
                        immediate:      immediate,
                        preload_offset: preload_offset,
                        preload_byte:   preload_byte};

endmodule

/* sv/mseu_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mseu_queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module mseu_queue #(
  parameter int unsigned DEPTH = mseu_pkg::QDEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mseu_pkg::entry_t push_entry,
  input  logic             pop,
  output mseu_pkg::entry_t head,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mseu_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

/* sv/mseu_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mseu_div
// Restoring 32-bit divider, one quotient bit per cycle, signed or unsigned.
// ----------------------------------------------------------------------------
module mseu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        sgn,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg_q;
  logic        neg_r;
  logic        na;
  logic        nb;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign na     = sgn & dividend[31];
  assign nb     = sgn & divisor[31];
  assign rem_sh = {rem, quo[31]};
  assign diff   = rem_sh - {1'b0, dvs};

  // Control: count 32 iterations, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load magnitudes, then shift and trial-subtract
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= na ? 32'd0 - dividend : dividend;
      dvs   <= nb ? 32'd0 - divisor : divisor;
      rem   <= '0;
      neg_q <= na ^ nb;
      neg_r <= na;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient  = neg_q ? 32'd0 - quo : quo;
  assign remainder = neg_r ? 32'd0 - rem : rem;

endmodule

/* sv/mseu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mseu_back
// Execution side: register file, HI/LO, data store, divider sequencing and
// the output register.
// ----------------------------------------------------------------------------
module mseu_back #(
  parameter int unsigned DATA_BYTES = mseu_pkg::DATA_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  mseu_pkg::entry_t   head,
  output logic               pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               reg_written,
  output logic [4:0]         reg_index,
  output logic signed [31:0] reg_value,
  output logic signed [31:0] hi_value,
  output logic signed [31:0] lo_value
);

  localparam int unsigned AW   = $clog2(DATA_BYTES);
  localparam logic [31:0] DB32 = 32'(DATA_BYTES);

  mseu_pkg::bstate_t state;
  mseu_pkg::bstate_t state_next;
  mseu_pkg::entry_t  cur;

  logic [31:0] rf [32];
  logic [31:0] rf_vld;
  logic [31:0] rs_q;
  logic [31:0] rt_q;
  logic [31:0] hi_reg;
  logic [31:0] lo_reg;

  logic [7:0]  store [DATA_BYTES];
  logic [7:0]  store_q;
  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] off_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          we;
  logic [7:0]    wr_data;
  logic [7:0]    byte_hi;

  mseu_pkg::status_t res_status;
  logic              res_wr;
  logic [31:0]       res_val;
  logic              res_hilo;
  logic [31:0]       res_hi;
  logic [31:0]       res_lo;

  mseu_pkg::status_t res_status_next;
  logic              res_wr_next;
  logic [31:0]       res_val_next;
  logic              res_load;
  logic              commit;
  logic              div_start;
  logic              div_sgn;
  logic              div_done;
  logic [31:0]       div_q;
  logic [31:0]       div_r;

  logic [31:0] simm;
  logic [31:0] addr;
  logic [31:0] ofs;
  logic        ok1;
  logic        ok2;
  logic        wr_eff;

  assign simm   = {{16{cur.immediate[15]}}, cur.immediate};
  assign addr   = rs_q + simm;
  assign ofs    = addr - mseu_pkg::DATA_BASE;
  assign ok1    = ofs < DB32;
  assign ok2    = ofs < (DB32 - 32'd1);
  assign wr_eff = res_wr && (cur.dest != 5'd0);
  assign clearing = (state == mseu_pkg::BS_CLEAR);

  mseu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .sgn       (div_sgn),
    .dividend  (rs_q),
    .divisor   (rt_q),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Next state, store port control and result values
  always_comb begin
    state_next      = state;
    pop             = 1'b0;
    res_load        = 1'b0;
    res_status_next = mseu_pkg::ST_OK;
    res_wr_next     = 1'b0;
    res_val_next    = '0;
    div_start       = 1'b0;
    div_sgn         = (cur.op == mseu_pkg::OP_DIV);
    commit          = 1'b0;
    we              = 1'b0;
    wr_addr         = clr_cnt;
    wr_data         = '0;
    rd_addr         = off_q;
    unique case (state)
      mseu_pkg::BS_CLEAR: begin
        we = 1'b1;
        if (clr_cnt == AW'(DATA_BYTES - 1)) begin
          state_next = mseu_pkg::BS_IDLE;
        end
      end
      mseu_pkg::BS_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = mseu_pkg::BS_READ;
        end
      end
      mseu_pkg::BS_READ: begin
        rd_addr    = ofs[AW-1:0];
        res_load   = 1'b1;
        state_next = mseu_pkg::BS_DONE;
        unique case (cur.op)
          mseu_pkg::OP_PRELOAD: begin
            wr_addr = AW'(cur.preload_offset);
            wr_data = cur.preload_byte;
            we      = ({16'd0, cur.preload_offset} < DB32);
          end
          mseu_pkg::OP_MFHI: begin
            res_wr_next  = 1'b1;
            res_val_next = hi_reg;
          end
          mseu_pkg::OP_MFLO: begin
            res_wr_next  = 1'b1;
            res_val_next = lo_reg;
          end
          mseu_pkg::OP_ADDU: begin
            res_wr_next  = 1'b1;
            res_val_next = rs_q + rt_q;
          end
          mseu_pkg::OP_AND: begin
            res_wr_next  = 1'b1;
            res_val_next = rs_q & rt_q;
          end
          mseu_pkg::OP_ADDIU: begin
            res_wr_next  = 1'b1;
            res_val_next = addr;
          end
          mseu_pkg::OP_ANDI: begin
            res_wr_next  = 1'b1;
            res_val_next = rs_q & {16'd0, cur.immediate};
          end
          mseu_pkg::OP_DIV, mseu_pkg::OP_DIVU: begin
            if (rt_q == 32'd0) begin
              res_status_next = mseu_pkg::ST_DIVZERO;
            end else begin
              div_start  = 1'b1;
              state_next = mseu_pkg::BS_DIV;
            end
          end
          mseu_pkg::OP_LB, mseu_pkg::OP_LBU: begin
            if (ok1) begin
              state_next = mseu_pkg::BS_MEM0;
            end else begin
              res_status_next = mseu_pkg::ST_BADMEM;
            end
          end
          mseu_pkg::OP_LH: begin
            if (ok2) begin
              state_next = mseu_pkg::BS_MEM0;
            end else begin
              res_status_next = mseu_pkg::ST_BADMEM;
            end
          end
          default: begin
            res_status_next = mseu_pkg::ST_INVALID;
          end
        endcase
      end
      mseu_pkg::BS_DIV: begin
        if (div_done) begin
          state_next = mseu_pkg::BS_DONE;
        end
      end
      mseu_pkg::BS_MEM0: begin
        rd_addr = off_q + 1'b1;
        if (cur.op == mseu_pkg::OP_LH) begin
          state_next = mseu_pkg::BS_MEM1;
        end else begin
          res_load     = 1'b1;
          res_wr_next  = 1'b1;
          res_val_next = {{24{store_q[7] & (cur.op == mseu_pkg::OP_LB)}}, store_q};
          state_next   = mseu_pkg::BS_DONE;
        end
      end
      mseu_pkg::BS_MEM1: begin
        res_load     = 1'b1;
        res_wr_next  = 1'b1;
        res_val_next = {{16{byte_hi[7]}}, byte_hi, store_q};
        state_next   = mseu_pkg::BS_DONE;
      end
      mseu_pkg::BS_DONE: begin
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          state_next = mseu_pkg::BS_IDLE;
        end
      end
      default: state_next = mseu_pkg::BS_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mseu_pkg::BS_CLEAR;
      clr_cnt   <= '0;
      rf_vld    <= '0;
      hi_reg    <= '0;
      lo_reg    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mseu_pkg::BS_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (commit) begin
        out_valid <= 1'b1;
        if (wr_eff) begin
          rf_vld[cur.dest] <= 1'b1;
        end
        if (res_hilo) begin
          hi_reg <= res_hi;
          lo_reg <= res_lo;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Register file write and registered reads
  always_ff @(posedge clk) begin
    if (commit && wr_eff) begin
      rf[cur.dest] <= res_val;
    end
    if (pop) begin
      cur  <= head;
      rs_q <= rf_vld[head.src1] ? rf[head.src1] : 32'd0;
      rt_q <= rf_vld[head.src2] ? rf[head.src2] : 32'd0;
    end
  end

  // Data store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      store[wr_addr] <= wr_data;
    end
    store_q <= store[rd_addr];
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (state == mseu_pkg::BS_READ) begin
      off_q    <= ofs[AW-1:0];
      res_hilo <= 1'b0;
    end
    if (state == mseu_pkg::BS_MEM0) begin
      byte_hi <= store_q;
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_wr     <= res_wr_next;
      res_val    <= res_val_next;
    end
    if (div_done && state == mseu_pkg::BS_DIV) begin
      res_status <= mseu_pkg::ST_OK;
      res_wr     <= 1'b0;
      res_val    <= '0;
      res_hilo   <= 1'b1;
      res_hi     <= div_r;
      res_lo     <= div_q;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (commit) begin
      status      <= res_status;
      reg_written <= wr_eff;
      reg_index   <= wr_eff ? cur.dest : 5'd0;
      reg_value   <= wr_eff ? res_val : 32'd0;
      hi_value    <= res_hilo ? res_hi : hi_reg;
      lo_value    <= res_hilo ? res_lo : lo_reg;
    end
  end

endmodule

/* sv/mips_subset_execute_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// Integer execute unit for a MIPS subset with register file, HI/LO and a
// byte data store.
//
// Input channel: in_valid/in_stall with func, code, register indexes,
// immediate and preload fields. Output channel: out_valid/out_stall with
// status, register write report and HI/LO. One result per input item.
// After reset the data store is swept to zero, one byte per cycle, through
// all DATA_BYTES bytes; in_stall stays high during that sweep.
// Halfword loads read their two bytes one after the other through the one
// store read port, one byte per cycle; divides take 32 radix-2 iterations.
// Items execute one at a time; a two-entry queue lets the input side keep
// taking transfers while the back end works. When out_stall is high the
// finished result holds in the output register and execution waits.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit #(
  parameter int unsigned DATA_BYTES = mseu_pkg::DATA_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [5:0]         code,
  input  logic [4:0]         src1,
  input  logic [4:0]         src2,
  input  logic [4:0]         dest,
  input  logic signed [15:0] immediate,
  input  logic [15:0]        preload_offset,
  input  logic [7:0]         preload_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               reg_written,
  output logic [4:0]         reg_index,
  output logic signed [31:0] reg_value,
  output logic signed [31:0] hi_value,
  output logic signed [31:0] lo_value
);

  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  logic             clearing;
  mseu_pkg::entry_t push_entry;
  mseu_pkg::entry_t head;

  mseu_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .code           (code),
    .src1           (src1),
    .src2           (src2),
    .dest           (dest),
    .immediate      (immediate),
    .preload_offset (preload_offset),
    .preload_byte   (preload_byte),
    .q_full         (q_full),
    .clearing       (clearing),
    .push           (push),
    .push_entry     (push_entry)
  );

  mseu_queue #(
    .DEPTH (mseu_pkg::QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  mseu_back #(
    .DATA_BYTES (DATA_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .reg_written (reg_written),
    .reg_index   (reg_index),
    .reg_value   (reg_value),
    .hi_value    (hi_value),
    .lo_value    (lo_value)
  );

endmodule

/* tb/sv/mips_subset_execute_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_execute_unit_test
// Drives decoded instructions and data preloads into the execute unit under
// random input gaps and output stalls, predicts each result from a local
// copy of the register file, HI/LO and data store, and compares field by
// field in transfer order.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit_test;

  localparam int unsigned STORE_BYTES = mseu_pkg::DATA_BYTES_DEF;
  localparam int unsigned RAND_ITEMS  = 950;
  localparam longint      CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  st;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic [31:0] hi;
    logic [31:0] lo;
  } outcome_t;

  typedef struct {
    logic [1:0]  fn;
    logic [5:0]  cd;
    logic [4:0]  s1;
    logic [4:0]  s2;
    logic [4:0]  d;
    logic [15:0] im;
    logic [15:0] po;
    logic [7:0]  pb;
    bit          fixed;
    outcome_t    res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = '0;
  logic [5:0] code = '0;
  logic [4:0] src1 = '0;
  logic [4:0] src2 = '0;
  logic [4:0] dest = '0;
  logic signed [15:0] immediate = '0;
  logic [15:0] preload_offset = '0;
  logic [7:0] preload_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic reg_written;
  logic [4:0] reg_index;
  logic signed [31:0] reg_value;
  logic signed [31:0] hi_value;
  logic signed [31:0] lo_value;

  mips_subset_execute_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .code(code), .src1(src1), .src2(src2), .dest(dest),
    .immediate(immediate), .preload_offset(preload_offset),
    .preload_byte(preload_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .reg_written(reg_written), .reg_index(reg_index),
    .reg_value(reg_value), .hi_value(hi_value), .lo_value(lo_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow architectural state
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q;
  logic [7:0]  mem_shadow [STORE_BYTES];

  outcome_t pending_results [$];
  int  mismatches = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  longint cycles = 0;

  // Check a load range against the store window
  function automatic bit in_store(logic [31:0] addr, int unsigned span,
                                  output logic [31:0] off);
    logic [31:0] o;
    o = addr - mseu_pkg::DATA_BASE;
    off = o;
    return (o < STORE_BYTES) && (STORE_BYTES - o >= span);
  endfunction

  // Execute one item on the shadow state and return its result
  function automatic outcome_t execute_item(row_t r);
    outcome_t o;
    logic [31:0] a, b, simm, val, off, q, rm, ua, ub;
    bit wr;
    a = gpr[r.s1];
    b = gpr[r.s2];
    simm = {{16{r.im[15]}}, r.im};
    val = '0;
    wr = 1'b0;
    o.st = mseu_pkg::ST_OK;
    if (r.fn == mseu_pkg::FN_PRELOAD) begin
      if (r.po < STORE_BYTES) mem_shadow[r.po] = r.pb;
    end else if (r.fn == mseu_pkg::FN_RTYPE) begin
      case (r.cd)
        mseu_pkg::RF_MFHI: begin val = hi_q; wr = 1'b1; end
        mseu_pkg::RF_MFLO: begin val = lo_q; wr = 1'b1; end
        mseu_pkg::RF_DIV: begin
          if (b == 0) o.st = mseu_pkg::ST_DIVZERO;
          else begin
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            q = ua / ub;
            rm = ua % ub;
            lo_q = (a[31] != b[31]) ? -q : q;
            hi_q = a[31] ? -rm : rm;
          end
        end
        mseu_pkg::RF_DIVU: begin
          if (b == 0) o.st = mseu_pkg::ST_DIVZERO;
          else begin
            lo_q = a / b;
            hi_q = a % b;
          end
        end
        mseu_pkg::RF_ADDU: begin val = a + b; wr = 1'b1; end
        mseu_pkg::RF_AND:  begin val = a & b; wr = 1'b1; end
        default: o.st = mseu_pkg::ST_INVALID;
      endcase
    end else if (r.fn == mseu_pkg::FN_ITYPE) begin
      case (r.cd)
        mseu_pkg::IO_ADDIU: begin val = a + simm; wr = 1'b1; end
        mseu_pkg::IO_ANDI:  begin val = a & {16'h0, r.im}; wr = 1'b1; end
        mseu_pkg::IO_LB, mseu_pkg::IO_LBU: begin
          if (!in_store(a + simm, 1, off)) o.st = mseu_pkg::ST_BADMEM;
          else begin
            val = {24'h0, mem_shadow[off]};
            if (r.cd == mseu_pkg::IO_LB && val[7]) val |= 32'hFFFF_FF00;
            wr = 1'b1;
          end
        end
        mseu_pkg::IO_LH: begin
          if (!in_store(a + simm, 2, off)) o.st = mseu_pkg::ST_BADMEM;
          else begin
            val = {16'h0, mem_shadow[off], mem_shadow[off + 1]};
            if (val[15]) val |= 32'hFFFF_0000;
            wr = 1'b1;
          end
        end
        default: o.st = mseu_pkg::ST_INVALID;
      endcase
    end else begin
      o.st = mseu_pkg::ST_INVALID;
    end
    if (wr && r.d != 0) gpr[r.d] = val;
    else wr = 1'b0;
    o.wr = wr;
    o.idx = wr ? r.d : 5'd0;
    o.val = wr ? val : 32'd0;
    o.hi = hi_q;
    o.lo = lo_q;
    return o;
  endfunction

  // Present one item and hold it until transferred
  task automatic send_item(row_t r);
    outcome_t exp_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= r.fn;
    code <= r.cd;
    src1 <= r.s1;
    src2 <= r.s2;
    dest <= r.d;
    immediate <= r.im;
    preload_offset <= r.po;
    preload_byte <= r.pb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_res = execute_item(r);
    if (r.fixed && exp_res != r.res) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table entry disagrees with prediction: table %h predicted %h",
                 r.res, exp_res);
    end
    pending_results.push_back(exp_res);
  endtask

  function automatic row_t mk(logic [1:0] fn, logic [5:0] cd, logic [4:0] s1,
                              logic [4:0] s2, logic [4:0] d, logic [15:0] im,
                              logic [15:0] po, logic [7:0] pb);
    row_t r;
    r.fn = fn; r.cd = cd; r.s1 = s1; r.s2 = s2; r.d = d;
    r.im = im; r.po = po; r.pb = pb;
    r.fixed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic row_t mkx(row_t r, logic [1:0] st, logic wr, logic [4:0] idx,
                               logic [31:0] val, logic [31:0] hi, logic [31:0] lo);
    r.fixed = 1'b1;
    r.res = '{st, wr, idx, val, hi, lo};
    return r;
  endfunction

  // Random item, mostly valid instructions aimed at the store
  function automatic row_t random_item();
    row_t r;
    logic [5:0] rcodes [6];
    logic [5:0] icodes [5];
    int sel;
    rcodes = '{mseu_pkg::RF_MFHI, mseu_pkg::RF_MFLO, mseu_pkg::RF_DIV,
               mseu_pkg::RF_DIVU, mseu_pkg::RF_ADDU, mseu_pkg::RF_AND};
    icodes = '{mseu_pkg::IO_ADDIU, mseu_pkg::IO_ANDI, mseu_pkg::IO_LB,
               mseu_pkg::IO_LH, mseu_pkg::IO_LBU};
    r = mk(2'($urandom), 6'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
           16'($urandom), 16'($urandom), 8'($urandom));
    sel = $urandom_range(99);
    if (sel < 20) begin
      r.fn = mseu_pkg::FN_PRELOAD;
      if ($urandom_range(3) != 0) r.po = 16'($urandom_range(63));
      else if ($urandom_range(1)) r.po = 16'(STORE_BYTES - 1 - $urandom_range(3));
    end else if (sel < 50) begin
      r.fn = mseu_pkg::FN_RTYPE;
      r.cd = rcodes[$urandom_range(5)];
      if (r.s2 < 4) r.s2 = 0;
    end else if (sel < 92) begin
      r.fn = mseu_pkg::FN_ITYPE;
      r.cd = icodes[$urandom_range(4)];
      // Sometimes zero the destination register
      if (r.cd == mseu_pkg::IO_ADDIU && $urandom_range(2) == 0) begin
        r.s1 = 0;
        r.im = 16'h0;
      end
      if (r.cd == mseu_pkg::IO_LB || r.cd == mseu_pkg::IO_LH ||
          r.cd == mseu_pkg::IO_LBU) begin
        if ($urandom_range(4) != 0) r.im = 16'($urandom_range(70) - 3);
      end
    end
    return r;
  endfunction

  row_t dir_rows [$];

  initial begin
    row_t r;
    int ph;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    hi_q = '0;
    lo_q = '0;
    for (int i = 0; i < STORE_BYTES; i++) mem_shadow[i] = '0;

    // Directed table: immediate extremes, register zero, error codes,
    // preloads and divides
    dir_rows.push_back(mkx(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_MFHI, 0, 0, 5, 0, 0, 0),
                           mseu_pkg::ST_OK, 1, 5, 0, 0, 0));
    dir_rows.push_back(mkx(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_ADDIU, 0, 0, 1, 16'h7FFF,
                              0, 0),
                           mseu_pkg::ST_OK, 1, 1, 32'h7FFF, 0, 0));
    dir_rows.push_back(mkx(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_ADDIU, 0, 0, 2, 16'h8000,
                              0, 0),
                           mseu_pkg::ST_OK, 1, 2, 32'hFFFF_8000, 0, 0));
    dir_rows.push_back(mkx(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_ANDI, 2, 0, 3, 16'hFFFF,
                              0, 0),
                           mseu_pkg::ST_OK, 1, 3, 32'h8000, 0, 0));
    dir_rows.push_back(mkx(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_ADDIU, 1, 0, 0, 1, 0, 0),
                           mseu_pkg::ST_OK, 0, 0, 0, 0, 0));
    dir_rows.push_back(mkx(mk(mseu_pkg::FN_JTYPE, 6'd2, 1, 1, 1, 0, 0, 0),
                           mseu_pkg::ST_INVALID, 0, 0, 0, 0, 0));
    dir_rows.push_back(mkx(mk(mseu_pkg::FN_RTYPE, 6'd63, 1, 1, 1, 0, 0, 0),
                           mseu_pkg::ST_INVALID, 0, 0, 0, 0, 0));
    dir_rows.push_back(mkx(mk(mseu_pkg::FN_ITYPE, 6'd0, 1, 1, 1, 0, 0, 0),
                           mseu_pkg::ST_INVALID, 0, 0, 0, 0, 0));
    dir_rows.push_back(mkx(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_DIV, 1, 0, 4, 0, 0, 0),
                           mseu_pkg::ST_DIVZERO, 0, 0, 0, 0, 0));
    dir_rows.push_back(mkx(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_DIVU, 1, 0, 4, 0, 0, 0),
                           mseu_pkg::ST_DIVZERO, 0, 0, 0, 0, 0));
    dir_rows.push_back(mkx(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_LB, 0, 0, 4, 0, 0, 0),
                           mseu_pkg::ST_BADMEM, 0, 0, 0, 0, 0));
    dir_rows.push_back(mkx(mk(mseu_pkg::FN_PRELOAD, 0, 0, 0, 0, 0, 16'd0, 8'hFF),
                           mseu_pkg::ST_OK, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(mseu_pkg::FN_PRELOAD, 0, 0, 0, 0, 0, 16'd1, 8'h80));
    dir_rows.push_back(mk(mseu_pkg::FN_PRELOAD, 0, 0, 0, 0, 0, 16'hFFFF, 8'h5A));
    // Signed divide: -32768 / 32767, unsigned divide, and -32768 / -1
    dir_rows.push_back(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_DIV, 2, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_DIVU, 2, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_MFLO, 0, 0, 6, 0, 0, 0));
    dir_rows.push_back(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_ADDU, 1, 2, 7, 0, 0, 0));
    dir_rows.push_back(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_AND, 2, 3, 8, 0, 0, 0));
    dir_rows.push_back(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_ADDIU, 0, 0, 9, 16'hFFFF, 0, 0));
    dir_rows.push_back(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_DIV, 2, 9, 0, 0, 0, 0));
    dir_rows.push_back(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_MFHI, 0, 0, 10, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // Point register 11 at the store base: 0x4000 doubled fifteen times
    send_item(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_ADDIU, 0, 0, 11, 16'h4000, 0, 0));
    for (int k = 0; k < 15; k++)
      send_item(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_ADDU, 11, 11, 11, 0, 0, 0));
    // Overflow divide: 0x80000000 / -1
    send_item(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_ADDU, 11, 11, 12, 0, 0, 0));
    send_item(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_ADDU, 12, 12, 12, 0, 0, 0));
    send_item(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_DIV, 12, 9, 0, 0, 0, 0));
    // Loads at the base, just below it, at the top byte, across the top end, and just past it
    send_item(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_LB, 11, 0, 13, 0, 0, 0));
    send_item(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_LBU, 11, 0, 13, 0, 0, 0));
    send_item(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_LH, 11, 0, 13, 0, 0, 0));
    send_item(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_LH, 11, 0, 13, -16'sd1, 0, 0));
    send_item(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_ADDU, 11, 0, 14, 0, 0, 0));
    send_item(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_ADDIU, 14, 0, 14, 16'h7FFF, 0, 0));
    send_item(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_ADDIU, 14, 0, 14, 16'h7FFF, 0, 0));
    send_item(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_LB, 14, 0, 15, 16'd1, 0, 0));
    send_item(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_LH, 14, 0, 15, 16'd1, 0, 0));
    send_item(mk(mseu_pkg::FN_ITYPE, mseu_pkg::IO_LB, 14, 0, 15, 16'd2, 0, 0));

    // Random part in phases of input idling and output stalls; reseed store pointers every 40 items
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin send_idle_pct = 60; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 60; end
        3: begin send_idle_pct = 35; recv_stall_pct = 35; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int k = 0; k < RAND_ITEMS / 5; k++) begin
        if (k % 40 == 0) begin
          for (int j = 16; j < 20; j++)
            send_item(mk(mseu_pkg::FN_RTYPE, mseu_pkg::RF_ADDU, 11, 0, 5'(j), 0, 0, 0));
        end
        r = random_item();
        if (r.fn == mseu_pkg::FN_ITYPE &&
            (r.cd == mseu_pkg::IO_LB || r.cd == mseu_pkg::IO_LH ||
             r.cd == mseu_pkg::IO_LBU) &&
            $urandom_range(3) != 0)
          r.s1 = 5'(16 + $urandom_range(3));
        if (r.d >= 11 && r.d <= 19 && $urandom_range(4) != 0) r.d = 5'd20 + r.d[2:0];
        send_item(r);
      end
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each transferred result against the oldest prediction
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, reg_written, reg_index, reg_value, hi_value, lo_value};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: st %0d/%0d wr %0d/%0d idx %0d/%0d",
                      " val %h/%h hi %h/%h lo %h/%h"},
                     want.st, got.st, want.wr, got.wr, want.idx, got.idx,
                     want.val, got.val, want.hi, got.hi, want.lo, got.lo);
        end
      end
    end
  end

  // Cycle limit: store clearing sweep plus every item at divide latency
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

/* sim.f */
sv/mseu_pkg.sv
sv/mseu_front.sv
sv/mseu_queue.sv
sv/mseu_div.sv
sv/mseu_back.sv
sv/mips_subset_execute_unit.sv
tb/sv/mips_subset_execute_unit_test.sv
